// ----- src/ttsf_pkg.sv -----
// Shared constants, types and character helpers for the tokenizer block.
`timescale 1ns / 1ps

package ttsf_pkg;

    localparam int MAX_TOKEN_BYTES = 32;
    localparam int MIN_TOKEN_BYTES = 2;

    // Token slots in the store: queue depth plus the slot under construction.
    localparam int NSLOT  = 3;
    localparam int SLOTW  = $clog2(NSLOT);
    localparam int QCNTW  = $clog2(NSLOT + 1);
    localparam int IDXW   = $clog2(MAX_TOKEN_BYTES);
    localparam int CNTW   = $clog2(MAX_TOKEN_BYTES + 1);
    // Length saturates one past the store size, enough to flag truncation.
    localparam int LENW   = $clog2(MAX_TOKEN_BYTES + 2);

    localparam int NWORD  = 23;
    localparam int WMAXW  = 3;

    // Drop list, first character in the top byte, zero padded.
    localparam logic [31:0] WORD_STR [NWORD] = '{
        {"the", 8'h00}, {"and", 8'h00}, {"or", 16'h0000}, {"in", 16'h0000},
        {"at", 16'h0000}, {"to", 16'h0000}, {"for", 8'h00}, "with", "from",
        {"of", 16'h0000}, {"a", 24'h000000}, {"an", 16'h0000},
        {"is", 16'h0000}, {"it", 16'h0000}, {"on", 16'h0000},
        {"by", 16'h0000}, {"as", 16'h0000}, {"be", 16'h0000}, "this", "that",
        {"are", 8'h00}, {"cd", 16'h0000}, {"pwd", 8'h00}
    };
    localparam logic [WMAXW-1:0] WORD_LEN [NWORD] = '{
        3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd2, 3'd1, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4, 3'd3, 3'd2, 3'd3
    };

    typedef struct packed {
        logic [CNTW-1:0] cnt;
        logic            trunc;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_push;

    typedef struct packed {
        logic            en;
        logic [SLOTW-1:0] slot;
        logic [IDXW-1:0]  idx;
        logic [7:0]       data;
    } t_wr_req;

    typedef struct packed {
        logic            en;
        logic [IDXW-1:0] idx;
    } t_rd_req;

    function automatic logic is_delim(input logic [7:0] b);
        return b == 8'h20 || b == 8'h2D || b == 8'h2F || b == 8'h2E ||
               b == 8'h5F || b == 8'h3D || b == 8'h3A || b == 8'h2C ||
               b == 8'h22 || b == 8'h27 || b == 8'h40 || b == 8'h28 ||
               b == 8'h29 || b == 8'h5B || b == 8'h5D;
    endfunction

    function automatic logic is_upper(input logic [7:0] b);
        return b >= 8'h41 && b <= 8'h5A;
    endfunction

    function automatic logic is_lower(input logic [7:0] b);
        return b >= 8'h61 && b <= 8'h7A;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic [SLOTW-1:0] slot_next(input logic [SLOTW-1:0] s);
        return (s == SLOTW'(NSLOT - 1)) ? '0 : s + SLOTW'(1);
    endfunction

endpackage

// ----- src/ttsf_ifs.sv -----
// Request channel interfaces: raw text bytes in, token bytes out.
`timescale 1ns / 1ps

interface ttsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_line;

    modport source (output valid, output in_byte, output end_of_line, input ready);
    modport sink   (input valid, input in_byte, input end_of_line, output ready);
endinterface

interface ttsf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       token_last;
    logic       token_truncated;

    modport source (output valid, output out_byte, output token_last,
                    output token_truncated, input ready);
    modport sink   (input valid, input out_byte, input token_last,
                    input token_truncated, output ready);
endinterface

// ----- src/ttsf_front.sv -----
// Front end: classifies bytes, builds the token, decides keep/drop, queues tokens.
`timescale 1ns / 1ps

module ttsf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [7:0]                 i_byte,
    input  logic                       i_eol,
    input  logic [ttsf_pkg::SLOTW-1:0] i_wslot,
    output ttsf_pkg::t_push            o_push,
    output ttsf_pkg::t_wr_req          o_wr
);

    logic [ttsf_pkg::LENW-1:0]  r_len,  n_len;
    logic                       r_dig,  n_dig;
    logic                       r_prev_lower, n_prev_lower;
    logic [ttsf_pkg::NWORD-1:0] r_match, n_match;

    logic                       delim, append, f1, keep1, keep2;
    logic [ttsf_pkg::LENW-1:0]  base_len, a_len;
    logic                       base_dig, a_dig;
    logic [ttsf_pkg::NWORD-1:0] a_match;
    logic [7:0]                 lc;

    function automatic logic keep_tok(input logic [ttsf_pkg::LENW-1:0]  len,
                                      input logic                       dig,
                                      input logic [ttsf_pkg::NWORD-1:0] m);
        logic hit;
        hit = 1'b0;
        for (int w = 0; w < ttsf_pkg::NWORD; w++) begin
            hit = hit | (m[w] && len == ttsf_pkg::LENW'(ttsf_pkg::WORD_LEN[w]));
        end
        return len >= ttsf_pkg::LENW'(ttsf_pkg::MIN_TOKEN_BYTES) && !dig &&
               !(len <= ttsf_pkg::LENW'(ttsf_pkg::MAX_TOKEN_BYTES) && hit);
    endfunction

    function automatic ttsf_pkg::t_desc make_desc(input logic [ttsf_pkg::LENW-1:0] len);
        ttsf_pkg::t_desc d;
        d.trunc = len > ttsf_pkg::LENW'(ttsf_pkg::MAX_TOKEN_BYTES);
        d.cnt   = d.trunc ? ttsf_pkg::CNTW'(ttsf_pkg::MAX_TOKEN_BYTES)
                          : len[ttsf_pkg::CNTW-1:0];
        return d;
    endfunction

    always_comb begin
        delim    = ttsf_pkg::is_delim(i_byte);
        append   = !delim;
        // camel boundary: uppercase right after lowercase closes the token
        f1       = delim || (ttsf_pkg::is_upper(i_byte) && r_prev_lower);
        keep1    = f1 && keep_tok(r_len, r_dig, r_match);
        base_len = f1 ? '0 : r_len;
        base_dig = f1 ? 1'b1 : r_dig;
        lc       = ttsf_pkg::is_upper(i_byte) ? i_byte + 8'h20 : i_byte;

        a_len = base_len;
        if (append && base_len != ttsf_pkg::LENW'(ttsf_pkg::MAX_TOKEN_BYTES + 1)) begin
            a_len = base_len + ttsf_pkg::LENW'(1);
        end
        a_dig = append ? (base_dig && ttsf_pkg::is_digit(i_byte)) : base_dig;

        // running prefix match against every drop-list word
        for (int w = 0; w < ttsf_pkg::NWORD; w++) begin
            a_match[w] = append &&
                         (base_len == '0 || r_match[w]) &&
                         base_len < ttsf_pkg::LENW'(ttsf_pkg::WORD_LEN[w]) &&
                         lc == ttsf_pkg::WORD_STR[w][31 - 8 * base_len[1:0] -: 8];
        end

        keep2 = i_eol && keep_tok(a_len, a_dig, a_match);

        o_push.valid = i_accept && (keep1 || keep2);
        o_push.desc  = keep1 ? make_desc(r_len) : make_desc(a_len);

        o_wr.en   = i_accept && append &&
                    base_len < ttsf_pkg::LENW'(ttsf_pkg::MAX_TOKEN_BYTES);
        o_wr.slot = keep1 ? ttsf_pkg::slot_next(i_wslot) : i_wslot;
        o_wr.idx  = base_len[ttsf_pkg::IDXW-1:0];
        o_wr.data = lc;

        n_len        = r_len;
        n_dig        = r_dig;
        n_prev_lower = r_prev_lower;
        n_match      = r_match;
        if (i_accept) begin
            if (i_eol) begin
                n_len        = '0;
                n_dig        = 1'b1;
                n_prev_lower = 1'b0;
                n_match      = '0;
            end else begin
                n_len        = a_len;
                n_dig        = a_dig;
                n_prev_lower = append && ttsf_pkg::is_lower(i_byte);
                n_match      = a_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len        <= '0;
            r_dig        <= 1'b1;
            r_prev_lower <= 1'b0;
            r_match      <= '0;
        end else begin
            r_len        <= n_len;
            r_dig        <= n_dig;
            r_prev_lower <= n_prev_lower;
            r_match      <= n_match;
        end
    end

endmodule

// ----- src/ttsf_queue.sv -----
// Token queue: descriptor FIFO plus the slotted token byte store.
`timescale 1ns / 1ps

module ttsf_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ttsf_pkg::t_push            i_push,
    input  ttsf_pkg::t_wr_req          i_wr,
    input  logic                       i_pop,
    input  ttsf_pkg::t_rd_req          i_rd,
    output logic                       o_room,
    output logic [ttsf_pkg::SLOTW-1:0] o_wslot,
    output logic                       o_head_valid,
    output ttsf_pkg::t_desc            o_head,
    output logic [7:0]                 o_rdata
);

    logic [7:0]                 r_mem [ttsf_pkg::NSLOT][ttsf_pkg::MAX_TOKEN_BYTES];
    ttsf_pkg::t_desc            r_desc [ttsf_pkg::NSLOT];
    logic [ttsf_pkg::SLOTW-1:0] r_wr_ptr, n_wr_ptr;
    logic [ttsf_pkg::SLOTW-1:0] r_rd_ptr, n_rd_ptr;
    logic [ttsf_pkg::QCNTW-1:0] r_count, n_count;
    logic [7:0]                 r_rdata;

    // one slot always stays free for the token under construction
    assign o_room       = r_count < ttsf_pkg::QCNTW'(ttsf_pkg::NSLOT - 1);
    assign o_wslot      = r_wr_ptr;
    assign o_head_valid = r_count != '0;
    assign o_head       = r_desc[r_rd_ptr];
    assign o_rdata      = r_rdata;

    always_comb begin
        n_wr_ptr = i_push.valid ? ttsf_pkg::slot_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ttsf_pkg::slot_next(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + ttsf_pkg::QCNTW'(1);
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - ttsf_pkg::QCNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_desc[r_wr_ptr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.slot][i_wr.idx] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[r_rd_ptr][i_rd.idx];
        end
    end

endmodule

// ----- src/ttsf_back.sv -----
// Back end: walks the head token byte by byte into the output register.
`timescale 1ns / 1ps

module ttsf_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  ttsf_pkg::t_desc    i_head,
    input  logic               i_out_ready,
    output ttsf_pkg::t_rd_req  o_rd,
    output logic               o_pop,
    output logic               o_valid,
    output logic               o_last,
    output logic               o_trunc
);

    logic [ttsf_pkg::IDXW-1:0] r_idx, n_idx;
    logic                      r_valid, n_valid;
    logic                      r_last, r_trunc;
    logic                      issue, last;

    always_comb begin
        issue    = i_head_valid && (!r_valid || i_out_ready);
        last     = ttsf_pkg::CNTW'(r_idx) + ttsf_pkg::CNTW'(1) == i_head.cnt;
        o_rd.en  = issue;
        o_rd.idx = r_idx;
        o_pop    = issue && last;

        n_idx   = r_idx;
        n_valid = r_valid;
        if (issue) begin
            n_idx   = last ? '0 : r_idx + ttsf_pkg::IDXW'(1);
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_last  <= last;
            r_trunc <= i_head.trunc;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_trunc = r_trunc;

endmodule

// ----- src/text_tokenizer_stopword_filter.sv -----
// Top level: byte tokenizer with camel split, lowercasing and drop-list filter.
// A kept token is queued first, then its first byte is read into the output register.
// Throughput: 1 input request per cycle while fewer than 2 finished tokens wait;
//   output drains 1 byte per cycle while the output is ready.
// Input stalls only when the queue holds 2 tokens (3-slot token store).
// Reset: synchronous, active low; clears control state, token store is not cleared.
`timescale 1ns / 1ps

module text_tokenizer_stopword_filter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ttsf_in_if.sink           i_in,
    ttsf_out_if.source        o_out
);

    ttsf_pkg::t_push            push;
    ttsf_pkg::t_wr_req          wr;
    ttsf_pkg::t_rd_req          rd;
    ttsf_pkg::t_desc            head;
    logic                       head_valid;
    logic                       pop;
    logic                       room;
    logic [ttsf_pkg::SLOTW-1:0] wslot;
    logic                       accept;

    // input side never waits on the output side unless the queue is full
    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    // front: classify each request, track the open token, hand off finished ones
    ttsf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_eol    (i_in.end_of_line),
        .i_wslot  (wslot),
        .o_push   (push),
        .o_wr     (wr)
    );

    // queue: decouples token building from token emission
    ttsf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_wr         (wr),
        .i_pop        (pop),
        .i_rd         (rd),
        .o_room       (room),
        .o_wslot      (wslot),
        .o_head_valid (head_valid),
        .o_head       (head),
        .o_rdata      (o_out.out_byte)
    );

    // back: one byte per cycle from the head token, stalls on the output
    ttsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .i_out_ready  (o_out.ready),
        .o_rd         (rd),
        .o_pop        (pop),
        .o_valid      (o_out.valid),
        .o_last       (o_out.token_last),
        .o_trunc      (o_out.token_truncated)
    );

endmodule

// ----- src/ttsf_checker.sv -----
// Port-level checks for the tokenizer, bound to the top level.
`timescale 1ns / 1ps

module ttsf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic       i_out_trunc
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last) &&
            $stable(i_out_trunc))
        else $error("stalled output request changed");

    a_lowercase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !ttsf_pkg::is_upper(i_out_byte))
        else $error("uppercase byte emitted");

    a_no_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !ttsf_pkg::is_delim(i_out_byte))
        else $error("delimiter byte emitted");

endmodule

bind text_tokenizer_stopword_filter ttsf_checker u_ttsf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.token_last),
    .i_out_trunc (o_out.token_truncated)
);
